// ===== rtl/lud_pkg.sv =====
package lud_pkg;

   // Matrix geometry
   localparam int MAX_ORDER     = 8;
   localparam int FRACTION_BITS = 16;
   localparam int DATA_W        = 32;
   localparam int IDX_W         = $clog2(MAX_ORDER);
   localparam int ORD_W         = $clog2(MAX_ORDER + 1);
   localparam int DEPTH         = MAX_ORDER * MAX_ORDER;
   localparam int ADDR_W        = $clog2(DEPTH);
   localparam int CNT_W         = $clog2(DEPTH + 1);
   localparam int SIZE_W        = 4;

   // Divider dividend is the numerator magnitude scaled by the fraction bits
   localparam int DIV_W  = DATA_W + FRACTION_BITS;
   localparam int WIDE_W = 2 * DATA_W;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [WIDE_W-1:0]        wide_type;

   localparam data_type ONE_VALUE = data_type'(1) <<< FRACTION_BITS;
   localparam data_type MAX_VALUE = {1'b0, {(DATA_W-1){1'b1}}};
   localparam data_type MIN_VALUE = {1'b1, {(DATA_W-1){1'b0}}};

   // Signed result from a sign and a magnitude, saturated to the data width.
   function automatic data_type sat_mag(input logic neg, input wide_type mag);
      logic over_pos;
      logic over_neg;
      over_pos = |mag[WIDE_W-1:DATA_W-1];
      over_neg = (|mag[WIDE_W-1:DATA_W]) || (mag[DATA_W-1] && (|mag[DATA_W-2:0]));
      if (neg) begin
         if (over_neg) begin
            sat_mag = MIN_VALUE;
         end else begin
            sat_mag = data_type'(-mag[DATA_W-1:0]);
         end
      end else begin
         if (over_pos) begin
            sat_mag = MAX_VALUE;
         end else begin
            sat_mag = data_type'(mag[DATA_W-1:0]);
         end
      end
   endfunction

endpackage

// ===== rtl/lud_cell.sv =====
module lud_cell
   import lud_pkg::*;
(
   input  logic     clock,
   input  logic     shift,
   input  data_type d_in,
   output data_type q
);

   data_type value_ff;
   data_type value_in;

   // Take the neighbor's entry whenever the chain advances.
   always_comb begin
      value_in = value_ff;
      if (shift) begin
         value_in = d_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign q = value_ff;

endmodule

// ===== rtl/lud_div.sv =====
module lud_div
   import lud_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  data_type numer,
   input  data_type denom,
   output logic     done,
   output data_type quot
);

   localparam int DCNT_W = $clog2(DIV_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DATA_W-1:0] dmag_ff, dmag_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W-1:0] num_mag;
   logic [DATA_W-1:0] den_mag;

   assign num_mag = numer[DATA_W-1] ? DATA_W'(-numer) : DATA_W'(numer);
   assign den_mag = denom[DATA_W-1] ? DATA_W'(-denom) : DATA_W'(denom);
   assign trial   = {rem_ff, dvd_ff[DIV_W-1]};

   // Restoring division of magnitudes, one quotient bit per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = {num_mag, {FRACTION_BITS{1'b0}}};
         quo_in  = '0;
         dmag_in = den_mag;
         neg_in  = numer[DATA_W-1] ^ denom[DATA_W-1];
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, dmag_ff}) begin
            rem_in = DATA_W'(trial - {1'b0, dmag_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   assign done = done_ff;
   assign quot = sat_mag(neg_ff, WIDE_W'(quo_ff));

   // A new division never starts while one is running.
   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");

   // Completion follows a busy cycle.
   a_done_after_busy : assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff)) else $error("divider done without work");

   // Busy ends exactly when done is raised.
   a_busy_ends : assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) && !start |-> done_ff) else $error("divider stopped early");

endmodule

// ===== rtl/lu_decomposition_no_pivot.sv =====
// Channel   Ports                                     Direction
// request   req_valid, req_ready, req_element         in, one element per transfer
// response  rsp_valid, rsp_ready, rsp_lower_value,    out, one L/U position per transfer
//           rsp_upper_value, rsp_row_index, rsp_col_index, rsp_zero_pivot, rsp_last
// config    csr_write_en, csr_write_data              in, matrix order, no wait
//
// Loading accepts one element per cycle. Elimination runs per column: a pivot read, a
// row load into the cell chain, and per lower row a divide plus the read, multiply, shift and
// subtract states per updated entry and one idle chain step per other cell; the divider sets the pace.
// Each result is read in S_ORD, registered in S_OSEND and held there while rsp_ready is low.
// Reset is synchronous and clears the control state; matrix order returns to eight.
// Elements are taken only while the block is loading; rsp_ready stalls hold the result.
module lu_decomposition_no_pivot
   import lud_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_element,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_lower_value,
   output logic signed [DATA_W-1:0] rsp_upper_value,
   output logic [IDX_W-1:0]         rsp_row_index,
   output logic [IDX_W-1:0]         rsp_col_index,
   output logic                     rsp_zero_pivot,
   output logic                     rsp_last,
   input  logic                     csr_write_en,
   input  logic [SIZE_W-1:0]        csr_write_data
);

   localparam logic [3:0] S_LOAD   = 4'd0;
   localparam logic [3:0] S_COL    = 4'd1;
   localparam logic [3:0] S_PIV_RD = 4'd2;
   localparam logic [3:0] S_PIV_WT = 4'd3;
   localparam logic [3:0] S_CLD    = 4'd4;
   localparam logic [3:0] S_CPSH   = 4'd5;
   localparam logic [3:0] S_LRD    = 4'd6;
   localparam logic [3:0] S_LWT    = 4'd7;
   localparam logic [3:0] S_DIV    = 4'd8;
   localparam logic [3:0] S_URD    = 4'd9;
   localparam logic [3:0] S_UMUL   = 4'd10;
   localparam logic [3:0] S_USHF   = 4'd11;
   localparam logic [3:0] S_USUB   = 4'd12;
   localparam logic [3:0] S_FIN    = 4'd13;
   localparam logic [3:0] S_ORD    = 4'd14;
   localparam logic [3:0] S_OSEND  = 4'd15;

   function automatic logic [ADDR_W-1:0] pos(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c,
                                             input logic [ORD_W-1:0] n);
      logic [CNT_W+ORD_W-1:0] full;
      full = (CNT_W+ORD_W)'(r) * (CNT_W+ORD_W)'(n) + (CNT_W+ORD_W)'(c);
      pos  = full[ADDR_W-1:0];
   endfunction

   // Control and counters
   logic [3:0]          state_ff, state_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                err_ff, err_in;
   logic [ORD_W-1:0]    n_ff, n_in;
   logic [IDX_W-1:0]    j_ff, j_in;
   logic [IDX_W-1:0]    i_ff, i_in;
   logic [ORD_W-1:0]    k_ff, k_in;
   logic [IDX_W-1:0]    t_ff, t_in;

   // Datapath registers
   data_type            pivot_ff, pivot_in;
   data_type            fac_ff, fac_in;
   data_type            a_ff, a_in;
   logic signed [WIDE_W-1:0] prod_ff;
   data_type            p_ff;

   // Result registers
   logic                rsp_valid_ff, rsp_valid_in;
   data_type            rsp_lower_ff, rsp_lower_in;
   data_type            rsp_upper_ff, rsp_upper_in;
   logic [IDX_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [IDX_W-1:0]    rsp_col_ff, rsp_col_in;
   logic                rsp_err_ff, rsp_err_in;
   logic                rsp_last_ff, rsp_last_in;

   // Memories
   data_type            work_mem [DEPTH];
   data_type            lower_mem [DEPTH];
   logic [ADDR_W-1:0]   rd_addr;
   data_type            work_rd_ff;
   data_type            lower_rd_ff;
   logic                wk_we;
   logic [ADDR_W-1:0]   wk_addr;
   data_type            wk_data;
   logic                lo_we;

   // Misc
   logic [ORD_W-1:0]    order;
   logic [IDX_W-1:0]    n_m1;
   logic [CNT_W-1:0]    total;
   logic [CNT_W-1:0]    count_next;
   logic                k_active;
   logic [IDX_W-1:0]    k_idx;
   logic                accept;
   logic                chain_shift;
   logic                chain_load;
   data_type            chain_din;
   data_type            cell_q [MAX_ORDER];
   logic                div_start;
   logic                div_done;
   data_type            div_quot;
   logic                prod_neg;
   wide_type            prod_mag;
   logic signed [DATA_W:0] diff;
   data_type            diff_sat;

   // Order in force: zero acts as one, values beyond the maximum clamp.
   always_comb begin
      if (size_ff == '0) begin
         order = ORD_W'(1);
      end else if (size_ff > SIZE_W'(MAX_ORDER)) begin
         order = ORD_W'(MAX_ORDER);
      end else begin
         order = ORD_W'(size_ff);
      end
   end

   assign total      = CNT_W'(order) * CNT_W'(order);
   assign count_next = count_ff + 1'b1;
   assign n_m1       = IDX_W'(n_ff - 1'b1);
   assign k_active   = k_ff < n_ff;
   assign k_idx      = k_ff[IDX_W-1:0];
   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == S_LOAD);

   // Pivot-row chain: a ring of cells that rotates one entry per step.
   generate
      for (genvar c = 0; c < MAX_ORDER; c++) begin : g_cell
         data_type nb;
         if (c == MAX_ORDER - 1) begin : g_tail
            assign nb = chain_load ? chain_din : cell_q[0];
         end else begin : g_body
            assign nb = cell_q[c+1];
         end
         lud_cell u_cell (
            .clock (clock),
            .shift (chain_shift),
            .d_in  (nb),
            .q     (cell_q[c])
         );
      end
   endgenerate

   // The leading entry is taken straight from the memory read register at start.
   lud_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (work_rd_ff),
      .denom (pivot_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Product magnitude for truncation toward zero.
   assign prod_neg = prod_ff[WIDE_W-1];
   assign prod_mag = prod_neg ? wide_type'(-prod_ff) : wide_type'(prod_ff);

   // Saturated difference.
   assign diff = {a_ff[DATA_W-1], a_ff} - {p_ff[DATA_W-1], p_ff};
   always_comb begin
      if (diff[DATA_W] != diff[DATA_W-1]) begin
         diff_sat = diff[DATA_W] ? MIN_VALUE : MAX_VALUE;
      end else begin
         diff_sat = data_type'(diff[DATA_W-1:0]);
      end
   end

   // Read address per state.
   always_comb begin
      case (state_ff)
         S_PIV_RD: rd_addr = pos(j_ff, j_ff, n_ff);
         S_CLD:    rd_addr = pos(j_ff, k_idx, n_ff);
         S_LRD:    rd_addr = pos(i_ff, j_ff, n_ff);
         S_URD:    rd_addr = pos(i_ff, k_idx, n_ff);
         default:  rd_addr = pos(i_ff, j_ff, n_ff);
      endcase
   end

   // Sequencer for load, elimination and readout.
   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      n_in         = n_ff;
      j_in         = j_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      t_in         = t_ff;
      pivot_in     = pivot_ff;
      fac_in       = fac_ff;
      a_in         = a_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_lower_in = rsp_lower_ff;
      rsp_upper_in = rsp_upper_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      wk_we        = 1'b0;
      wk_addr      = pos(i_ff, j_ff, n_ff);
      wk_data      = '0;
      lo_we        = 1'b0;
      chain_shift  = 1'b0;
      chain_load   = 1'b0;
      chain_din    = '0;
      div_start    = 1'b0;

      if (csr_write_en) begin
         size_in = csr_write_data;
      end

      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               wk_we    = 1'b1;
               wk_addr  = count_ff[ADDR_W-1:0];
               wk_data  = req_element;
               count_in = count_next;
               if (count_next >= total) begin
                  n_in     = order;
                  j_in     = '0;
                  state_in = S_COL;
               end
            end
         end
         S_COL: begin
            if (ORD_W'(j_ff) + 1'b1 >= n_ff) begin
               i_in     = '0;
               j_in     = '0;
               state_in = S_ORD;
            end else begin
               state_in = S_PIV_RD;
            end
         end
         S_PIV_RD: begin
            state_in = S_PIV_WT;
         end
         S_PIV_WT: begin
            pivot_in = work_rd_ff;
            k_in     = ORD_W'(j_ff) + 1'b1;
            t_in     = '0;
            state_in = S_CLD;
         end
         S_CLD: begin
            state_in = S_CPSH;
         end
         S_CPSH: begin
            chain_shift = 1'b1;
            chain_load  = 1'b1;
            chain_din   = k_active ? work_rd_ff : '0;
            k_in        = k_ff + 1'b1;
            t_in        = t_ff + 1'b1;
            if (t_ff == IDX_W'(MAX_ORDER - 1)) begin
               i_in     = j_ff + 1'b1;
               state_in = S_LRD;
            end else begin
               state_in = S_CLD;
            end
         end
         S_LRD: begin
            k_in     = ORD_W'(j_ff) + 1'b1;
            t_in     = '0;
            state_in = S_LWT;
         end
         S_LWT: begin
            a_in = work_rd_ff;
            if (pivot_ff == '0) begin
               fac_in   = '0;
               err_in   = 1'b1;
               state_in = S_URD;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               fac_in   = div_quot;
               state_in = S_URD;
            end
         end
         S_URD: begin
            if (k_active) begin
               state_in = S_UMUL;
            end else begin
               chain_shift = 1'b1;
               t_in        = t_ff + 1'b1;
               if (t_ff == IDX_W'(MAX_ORDER - 1)) begin
                  state_in = S_FIN;
               end
            end
         end
         S_UMUL: begin
            a_in     = work_rd_ff;
            state_in = S_USHF;
         end
         S_USHF: begin
            state_in = S_USUB;
         end
         S_USUB: begin
            wk_we       = 1'b1;
            wk_addr     = pos(i_ff, k_idx, n_ff);
            wk_data     = diff_sat;
            chain_shift = 1'b1;
            k_in        = k_ff + 1'b1;
            t_in        = t_ff + 1'b1;
            if (t_ff == IDX_W'(MAX_ORDER - 1)) begin
               state_in = S_FIN;
            end else begin
               state_in = S_URD;
            end
         end
         S_FIN: begin
            wk_we   = 1'b1;
            wk_addr = pos(i_ff, j_ff, n_ff);
            wk_data = '0;
            lo_we   = 1'b1;
            if (i_ff == n_m1) begin
               j_in     = j_ff + 1'b1;
               state_in = S_COL;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_LRD;
            end
         end
         S_ORD: begin
            // Readout reuses i as row and j as column; read address is pos(i, j).
            state_in = S_OSEND;
         end
         S_OSEND: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = i_ff;
               rsp_col_in   = j_ff;
               rsp_err_in   = err_ff;
               rsp_last_in  = (i_ff == n_m1) && (j_ff == n_m1);
               if (i_ff == j_ff) begin
                  rsp_lower_in = ONE_VALUE;
               end else if (i_ff > j_ff) begin
                  rsp_lower_in = lower_rd_ff;
               end else begin
                  rsp_lower_in = '0;
               end
               rsp_upper_in = (i_ff > j_ff) ? data_type'(0) : work_rd_ff;
            end else if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in = '0;
                  err_in   = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  if (j_ff == n_m1) begin
                     j_in = '0;
                     i_in = i_ff + 1'b1;
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
                  state_in = S_ORD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // The divider starts as the leading entry arrives from memory.
      if (state_ff == S_LWT && pivot_ff != '0) begin
         div_start = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         size_ff      <= SIZE_W'(MAX_ORDER);
         count_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and counter registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      j_ff         <= j_in;
      i_ff         <= i_in;
      k_ff         <= k_in;
      t_ff         <= t_in;
      pivot_ff     <= pivot_in;
      fac_ff       <= fac_in;
      a_ff         <= a_in;
      prod_ff      <= fac_ff * cell_q[0];
      p_ff         <= sat_mag(prod_neg, prod_mag >> FRACTION_BITS);
      rsp_lower_ff <= rsp_lower_in;
      rsp_upper_ff <= rsp_upper_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Working and factor memories with registered reads.
   always_ff @(posedge clock) begin
      if (wk_we) begin
         work_mem[wk_addr] <= wk_data;
      end
      if (lo_we) begin
         lower_mem[pos(i_ff, j_ff, n_ff)] <= fac_ff;
      end
      work_rd_ff  <= work_mem[rd_addr];
      lower_rd_ff <= lower_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_lower_value = rsp_lower_ff;
   assign rsp_upper_value = rsp_upper_ff;
   assign rsp_row_index   = rsp_row_ff;
   assign rsp_col_index   = rsp_col_ff;
   assign rsp_zero_pivot  = rsp_err_ff;
   assign rsp_last        = rsp_last_ff;

   // No element is taken while a result is pending.
   a_no_load_during_output : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready) else $error("load while result pending");

   // The divider only completes while the sequencer waits for it.
   a_div_done_in_wait : assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV) else $error("divider done outside wait");

   // The load count never passes the store depth.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("load count out of range");

   // After the final transfer the block is loading again with a clean count.
   a_restart_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && rsp_last_ff |=> state_ff == S_LOAD && count_ff == '0)
      else $error("no clean restart after final result");

endmodule
